>>> rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and fixed constants of the hsv to rgb conversion pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // fixed field widths
    localparam int unsigned HUE_W = 13;
    localparam int unsigned CH_W  = 8;

    // color space constants
    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned TURN_DEG   = 360;

    // pipeline stage map
    localparam int unsigned NSTG    = 5;
    localparam int unsigned ST_HMOD = 0;
    localparam int unsigned ST_SEC  = 1;
    localparam int unsigned ST_NUM  = 2;
    localparam int unsigned ST_PROD = 3;
    localparam int unsigned ST_RCP  = 4;

    // divide by 255*60*2^frac: drop 2^(frac+2), then divide by 3825
    localparam int unsigned PRE_SHIFT = 2;
    localparam int unsigned DIV_C     = FULL_SCALE * SECTOR_DEG / (1 << PRE_SHIFT);
    // largest quotient input: 255*255*15 fits in 20 bits
    localparam int unsigned Z_W       = 20;

    // reciprocal of DIV_C, exact for every Z_W-bit dividend
    localparam int unsigned     RECIP_SHIFT = 32;
    localparam int unsigned     RECIP_W     = 21;
    localparam longint unsigned RECIP_L     =
        ((64'd1 << RECIP_SHIFT) + 64'(DIV_C) - 64'd1) / 64'(DIV_C);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);

    // hue sectors, 60 degrees each
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    // per-stage load enables
    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_pipe_ctl;

endpackage

>>> rtl/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to 8-bit RGB pixel converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one pixel word (hue, saturation,
//   brightness); a word is taken on a clock edge with i_valid high and o_stall
//   low. Output channel o_valid / i_stall carries one rgb word per pixel.
//   A word passes through the pipeline register stages (hue wrap, sector
//   split, numerator multiply, value multiply, reciprocal multiply) before
//   o_valid rises. Throughput is one pixel per cycle while the receiver does
//   not stall; each stage takes a new word every cycle when it is empty or
//   the next stage moves.
//   When the receiver stalls, the last stage holds its word and stalls fill
//   backward one stage at a time; empty stages keep accepting, so o_stall rises
//   only when every stage holds a word. No word is lost or repeated.
//   Synchronous active-low reset empties the pipeline; payload registers are
//   not cleared. Hue of a full turn or more wraps; zero saturation gives grey.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top import hsvrgb_pkg::*; #(
    parameter int unsigned HUE_FRAC_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [CH_W-1:0]  i_saturation,
    input  logic [CH_W-1:0]  i_brightness,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CH_W-1:0]  o_red,
    output logic [CH_W-1:0]  o_green,
    output logic [CH_W-1:0]  o_blue
);

    localparam int unsigned SW  = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int unsigned K_W = $clog2(SW + 1);

    t_pipe_ctl       ctl;
    logic [NSTG-1:0] r_vld;
    logic [CH_W-1:0] r_sat  [0:ST_SEC];
    logic [CH_W-1:0] r_bri  [0:NSTG-1];
    logic            r_zero [0:NSTG-1];
    t_sector         r_sec  [ST_SEC+1:NSTG-1];
    t_sector         sector;
    logic [K_W-1:0]  kq;
    logic [K_W-1:0]  kt;
    logic [CH_W-1:0] ch_p;
    logic [CH_W-1:0] ch_q;
    logic [CH_W-1:0] ch_t;

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        ctl.en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int i = NSTG - 2; i >= 0; i--) begin
            ctl.en[i] = !r_vld[i] || ctl.en[i+1];
        end
    end

    assign o_stall = !ctl.en[0];
    assign o_valid = r_vld[NSTG-1];

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ctl.en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (ctl.en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // side band: saturation, brightness, grey flag, sector
    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_sat[0]  <= i_saturation;
            r_bri[0]  <= i_brightness;
            r_zero[0] <= (i_saturation == '0);
        end
        for (int i = 1; i <= ST_SEC; i++) begin
            if (ctl.en[i]) begin
                r_sat[i] <= r_sat[i-1];
            end
        end
        for (int i = 1; i < NSTG; i++) begin
            if (ctl.en[i]) begin
                r_bri[i]  <= r_bri[i-1];
                r_zero[i] <= r_zero[i-1];
            end
        end
        if (ctl.en[ST_SEC+1]) begin
            r_sec[ST_SEC+1] <= sector;
        end
        for (int i = ST_SEC + 2; i < NSTG; i++) begin
            if (ctl.en[i]) begin
                r_sec[i] <= r_sec[i-1];
            end
        end
    end

    // hue wrap and sector split
    hsvrgb_hue_split #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_hue_split (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_hue    (i_hue),
        .o_sector (sector),
        .o_kq     (kq),
        .o_kt     (kt)
    );

    // p channel: full sector width
    hsvrgb_chan_calc #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_chan_p (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_sat (r_sat[ST_SEC]),
        .i_bri (r_bri[ST_SEC]),
        .i_k   (K_W'(SW)),
        .o_ch  (ch_p)
    );

    // q channel: remainder
    hsvrgb_chan_calc #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_chan_q (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_sat (r_sat[ST_SEC]),
        .i_bri (r_bri[ST_SEC]),
        .i_k   (kq),
        .o_ch  (ch_q)
    );

    // t channel: width minus remainder
    hsvrgb_chan_calc #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_chan_t (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_sat (r_sat[ST_SEC]),
        .i_bri (r_bri[ST_SEC]),
        .i_k   (kt),
        .o_ch  (ch_t)
    );

    // six-sector placement, grey when saturation is zero
    always_comb begin
        unique case (r_sec[NSTG-1])
            SEC_RED: begin
                o_red = r_bri[NSTG-1]; o_green = ch_t; o_blue = ch_p;
            end
            SEC_YELLOW: begin
                o_red = ch_q; o_green = r_bri[NSTG-1]; o_blue = ch_p;
            end
            SEC_GREEN: begin
                o_red = ch_p; o_green = r_bri[NSTG-1]; o_blue = ch_t;
            end
            SEC_CYAN: begin
                o_red = ch_p; o_green = ch_q; o_blue = r_bri[NSTG-1];
            end
            SEC_BLUE: begin
                o_red = ch_t; o_green = ch_p; o_blue = r_bri[NSTG-1];
            end
            default: begin
                o_red = r_bri[NSTG-1]; o_green = ch_p; o_blue = ch_q;
            end
        endcase
        if (r_zero[NSTG-1]) begin
            o_red   = r_bri[NSTG-1];
            o_green = r_bri[NSTG-1];
            o_blue  = r_bri[NSTG-1];
        end
    end

endmodule

>>> rtl/hsvrgb_hue_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_hue_split
// Two pipeline stages: wrap hue into one turn, then split it into a sector
// and the offsets used for the q and t channels.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split import hsvrgb_pkg::*; #(
    parameter int unsigned HUE_FRAC_BITS = 4
) (
    input  logic                                   i_clk,
    input  t_pipe_ctl                              i_ctl,
    input  logic [HUE_W-1:0]                       i_hue,
    output t_sector                                o_sector,
    output logic [$clog2((SECTOR_DEG << HUE_FRAC_BITS) + 1)-1:0] o_kq,
    output logic [$clog2((SECTOR_DEG << HUE_FRAC_BITS) + 1)-1:0] o_kt
);

    localparam int unsigned SW         = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int unsigned FT         = TURN_DEG << HUE_FRAC_BITS;
    localparam int unsigned HUE_MAX    = (1 << HUE_W) - 1;
    localparam int          WRAP_STEPS = $clog2(HUE_MAX / FT + 1);
    localparam int unsigned K_W        = $clog2(SW + 1);

    logic [HUE_W-1:0] n_h;
    logic [HUE_W-1:0] r_h;
    logic [HUE_W-1:0] n_rm;
    logic [2:0]       n_q;
    t_sector          r_sector;
    logic [K_W-1:0]   r_kq;
    logic [K_W-1:0]   r_kt;

    // wrap modulo a full turn by restoring subtraction
    always_comb begin
        n_h = i_hue;
        for (int j = WRAP_STEPS - 1; j >= 0; j--) begin
            if (32'(n_h) >= (FT << j)) begin
                n_h = n_h - HUE_W'(FT << j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_HMOD]) begin
            r_h <= n_h;
        end
    end

    // sector quotient and remainder, three quotient bits
    always_comb begin
        n_rm = r_h;
        n_q  = '0;
        for (int j = 2; j >= 0; j--) begin
            if (32'(n_rm) >= (SW << j)) begin
                n_rm   = n_rm - HUE_W'(SW << j);
                n_q[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_SEC]) begin
            r_sector <= t_sector'(n_q);
            r_kq     <= K_W'(n_rm);
            r_kt     <= K_W'(SW) - K_W'(n_rm);
        end
    end

    assign o_sector = r_sector;
    assign o_kq     = r_kq;
    assign o_kt     = r_kt;

endmodule

>>> rtl/hsvrgb_chan_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_chan_calc
// Three pipeline stages computing floor(v * (1 - s*k/width)) scaled to 8 bits:
// numerator, product with value, reciprocal divide.
// ----------------------------------------------------------------------------
module hsvrgb_chan_calc import hsvrgb_pkg::*; #(
    parameter int unsigned HUE_FRAC_BITS = 4
) (
    input  logic                                   i_clk,
    input  t_pipe_ctl                              i_ctl,
    input  logic [CH_W-1:0]                        i_sat,
    input  logic [CH_W-1:0]                        i_bri,
    input  logic [$clog2((SECTOR_DEG << HUE_FRAC_BITS) + 1)-1:0] i_k,
    output logic [CH_W-1:0]                        o_ch
);

    localparam int unsigned SW        = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int unsigned SCALE_NUM = FULL_SCALE * SW;
    localparam int unsigned NUM_W     = $clog2(SCALE_NUM + 1);
    localparam int unsigned PROD_W    = CH_W + NUM_W;
    localparam int unsigned RCP_PW    = Z_W + RECIP_W;

    logic [NUM_W-1:0]  n_num;
    logic [NUM_W-1:0]  r_num;
    logic [CH_W-1:0]   r_bri;
    logic [PROD_W-1:0] n_prod;
    logic [Z_W-1:0]    r_z;
    logic [RCP_PW-1:0] n_rcp;
    logic [CH_W-1:0]   r_ch;

    // numerator: full scale minus s*k
    assign n_num = NUM_W'(SCALE_NUM) - NUM_W'(i_sat) * NUM_W'(i_k);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_NUM]) begin
            r_num <= n_num;
            r_bri <= i_bri;
        end
    end

    // product with value, drop the power of two part of the divisor
    assign n_prod = PROD_W'(r_bri) * PROD_W'(r_num);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_PROD]) begin
            r_z <= Z_W'(n_prod >> (HUE_FRAC_BITS + PRE_SHIFT));
        end
    end

    // divide by the odd part through the reciprocal
    assign n_rcp = RCP_PW'(r_z) * RCP_PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_RCP]) begin
            r_ch <= n_rcp[RECIP_SHIFT +: CH_W];
        end
    end

    assign o_ch = r_ch;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hsv to rgb pixel converter. A directed table
// covers grey pixels, the primary and secondary hues, hue wrap and the field
// extremes. Random pixels then run through phases of sender idling and
// receiver stalling. Each output word is checked against the table or a model.
// ----------------------------------------------------------------------------
module tb;
    import hsvrgb_pkg::*;

    localparam int unsigned      HUE_FRAC_BITS = 4;
    localparam longint unsigned  SECTOR_LEN    = longint'(SECTOR_DEG) << HUE_FRAC_BITS;
    localparam longint unsigned  TURN_LEN      = longint'(TURN_DEG) << HUE_FRAC_BITS;
    localparam int unsigned      HUE_MAX       = (1 << HUE_W) - 1;
    localparam int unsigned      N_DIR         = 23;
    localparam int unsigned      N_PHASES      = 4;
    localparam int unsigned      PHASE_ITEMS   = 232;
    localparam int unsigned      HOLD_CYCLES   = 200;
    localparam int unsigned      DRAIN_CYCLES  = 10;
    localparam int unsigned      WATCHDOG_MAX  = 4000;

    // idle and stall percentages of each random phase
    localparam int IDLE_PCT  [N_PHASES] = '{0, 70, 0, 7};
    localparam int STALL_PCT [N_PHASES] = '{0, 0, 70, 7};

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        logic             typed;
        t_rgb             want;
    } t_pixel_row;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic             o_stall;
    logic [HUE_W-1:0] i_hue        = '0;
    logic [CH_W-1:0]  i_saturation = '0;
    logic [CH_W-1:0]  i_brightness = '0;
    logic             o_valid;
    logic             i_stall      = 1'b0;
    logic [CH_W-1:0]  o_red;
    logic [CH_W-1:0]  o_green;
    logic [CH_W-1:0]  o_blue;

    t_rgb rgb_due[$];
    int   errors         = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    // directed pixels: grey, primaries and secondaries, hue wrap, extremes
    t_pixel_row dir_rows [N_DIR] = '{
        '{13'd0,    8'd0,   8'd0,   1'b1, 24'h000000},
        '{13'd0,    8'd0,   8'd255, 1'b1, 24'hFFFFFF},
        '{13'd3000, 8'd0,   8'd128, 1'b1, 24'h808080},
        '{13'd0,    8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{13'd5760, 8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{13'd960,  8'd255, 8'd255, 1'b1, 24'hFFFF00},
        '{13'd1920, 8'd255, 8'd255, 1'b1, 24'h00FF00},
        '{13'd2880, 8'd255, 8'd255, 1'b1, 24'h00FFFF},
        '{13'd3840, 8'd255, 8'd255, 1'b1, 24'h0000FF},
        '{13'd4800, 8'd255, 8'd255, 1'b1, 24'hFF00FF},
        '{13'd2000, 8'd255, 8'd0,   1'b1, 24'h000000},
        '{13'd480,  8'd255, 8'd255, 1'b0, 24'h000000},
        '{13'd1440, 8'd200, 8'd100, 1'b0, 24'h000000},
        '{13'd2400, 8'd128, 8'd200, 1'b0, 24'h000000},
        '{13'd3360, 8'd1,   8'd255, 1'b0, 24'h000000},
        '{13'd4320, 8'd255, 8'd17,  1'b0, 24'h000000},
        '{13'd5280, 8'd77,  8'd240, 1'b0, 24'h000000},
        '{13'd5759, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{13'd8191, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{13'd6720, 8'd170, 8'd85,  1'b0, 24'h000000},
        '{13'd959,  8'd255, 8'd255, 1'b0, 24'h000000},
        '{13'd1,    8'd254, 8'd254, 1'b0, 24'h000000},
        '{13'd0,    8'd1,   8'd1,   1'b0, 24'h000000}
    };

    hsv_to_rgb_converter_top #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // floor(v * (1 - s/255 * k/sector)) scaled back to 0..255
    function automatic logic [CH_W-1:0] fade_channel(logic [CH_W-1:0] val,
                                                     logic [CH_W-1:0] sat,
                                                     longint unsigned k);
        longint unsigned den;
        longint unsigned num;
        den = longint'(FULL_SCALE) * SECTOR_LEN;
        num = den - longint'(sat) * k;
        return CH_W'((longint'(val) * num) / den);
    endfunction

    // expected rgb word for one hsv pixel
    function automatic t_rgb predict_rgb(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                         logic [CH_W-1:0] val);
        longint unsigned wrapped;
        longint unsigned rem;
        t_sector         sec;
        logic [CH_W-1:0] pp;
        logic [CH_W-1:0] qq;
        logic [CH_W-1:0] tt;
        t_rgb            px;
        if (sat == '0) begin
            px = {val, val, val};
            return px;
        end
        wrapped = longint'(hue) % TURN_LEN;
        sec     = t_sector'(3'(wrapped / SECTOR_LEN));
        rem     = wrapped % SECTOR_LEN;
        pp      = fade_channel(val, sat, SECTOR_LEN);
        qq      = fade_channel(val, sat, rem);
        tt      = fade_channel(val, sat, SECTOR_LEN - rem);
        case (sec)
            SEC_RED:     px = {val, tt, pp};
            SEC_YELLOW:  px = {qq, val, pp};
            SEC_GREEN:   px = {pp, val, tt};
            SEC_CYAN:    px = {pp, qq, val};
            SEC_BLUE:    px = {tt, pp, val};
            default:     px = {val, pp, qq};
        endcase
        return px;
    endfunction

    // hue: mostly inside the turn, some near sector edges, some past the turn
    function automatic logic [HUE_W-1:0] random_hue();
        int unsigned pick;
        int unsigned sec;
        pick = $urandom_range(9);
        sec  = $urandom_range(5);
        case (pick)
            0: return HUE_W'($urandom_range(HUE_MAX, int'(TURN_LEN) + 1));
            1: return HUE_W'(sec * int'(SECTOR_LEN));
            2: return HUE_W'(sec * int'(SECTOR_LEN) + 1);
            3: return HUE_W'(sec * int'(SECTOR_LEN) + int'(SECTOR_LEN) - 1);
            default: return HUE_W'($urandom_range(int'(TURN_LEN)));
        endcase
    endfunction

    // channel fraction with extra weight on 0 and full scale
    function automatic logic [CH_W-1:0] random_level();
        int unsigned pick;
        pick = $urandom_range(9);
        case (pick)
            0: return '0;
            1: return CH_W'(FULL_SCALE);
            default: return CH_W'($urandom_range(FULL_SCALE));
        endcase
    endfunction

    // offer one pixel word, with optional idle gap, and wait until taken
    task automatic send_pixel(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                              logic [CH_W-1:0] val, t_rgb want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rgb_due.push_back(want);
    endtask

    // hold the sender until every word in flight has come out
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rgb_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // output word check against the oldest expectation
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rgb_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d %0d %0d",
                         $time, o_red, o_green, o_blue);
                errors++;
            end else begin
                want = rgb_due.pop_front();
                check_channel("red",   want.red,   o_red);
                check_channel("green", want.green, o_green);
                check_channel("blue",  want.blue,  o_blue);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_rgb want;
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        foreach (dir_rows[n]) begin
            want = dir_rows[n].typed ? dir_rows[n].want
                                     : predict_rgb(dir_rows[n].hue, dir_rows[n].sat,
                                                   dir_rows[n].val);
            send_pixel(dir_rows[n].hue, dir_rows[n].sat, dir_rows[n].val, want);
        end
        drain_pipeline();

        // random phases
        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct  = IDLE_PCT[ph];
            recv_stall_pct = STALL_PCT[ph];
            // long receiver hold-off while the sender keeps offering
            if (ph == 0) hold_left = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                hue = random_hue();
                sat = random_level();
                val = random_level();
                send_pixel(hue, sat, val, predict_rgb(hue, sat, val));
            end
            drain_pipeline();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && rgb_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_hue_split.sv
rtl/hsvrgb_chan_calc.sv
rtl/hsv_to_rgb_converter_top.sv
tb/sv/tb.sv
